[src/mma_pkg.sv]
`timescale 1ns / 1ps

package mma_pkg;

   localparam int VALUE_W = 32;
   localparam int INDEX_W = 6;
   localparam int KIND_W = 3;
   localparam int SIZE_W = 7;
   localparam int PROD_W = 2 * VALUE_W;
   localparam int FRAC_W = 16;

   localparam logic [KIND_W-1:0] KIND_WRITE_A = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE_B = 3'd1;
   localparam logic [KIND_W-1:0] KIND_WRITE_C = 3'd2;
   localparam logic [KIND_W-1:0] KIND_COMPUTE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ_C = 3'd4;

   localparam logic [SIZE_W-1:0] SIZE_N_RESET = 7'd64;

   localparam logic [VALUE_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] Q_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] result_value;
      logic is_done;
      logic saturated;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic issue;
   } dot_ctl_type;

endpackage

[src/mma_ram.sv]
`timescale 1ns / 1ps

module mma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input logic clock,
   input logic wr_en,
   input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic rd_en,
   input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/mma_dot.sv]
`timescale 1ns / 1ps

module mma_dot #(
   parameter int ACC_W = 70
) (
   input logic clock,
   input logic reset,
   input mma_pkg::dot_ctl_type ctl,
   input logic signed [mma_pkg::VALUE_W-1:0] a_data,
   input logic signed [mma_pkg::VALUE_W-1:0] b_data,
   output logic signed [ACC_W-1:0] acc,
   output logic busy
);

   import mma_pkg::*;

   logic operand_valid_ff;
   logic prod_valid_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;

   // Operands arrive in the cycle after the read is issued; the product is
   // registered before it enters the accumulator.
   always_ff @(posedge clock) begin
      if (reset) begin
         operand_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         operand_valid_ff <= ctl.issue;
         prod_valid_ff <= operand_valid_ff;
      end
      prod_ff <= a_data * b_data;
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   assign acc = acc_ff;
   assign busy = operand_valid_ff | prod_valid_ff;

endmodule

[src/matrix_multiply_accumulate.sv]
`timescale 1ns / 1ps
// Element writes land when accepted; a read of C gives its beat once the response slot is free.
// A compute runs to its done beat with n = min(size_n, MAX_N): each element of C
// runs its n products through the single multiply-accumulate unit, one A and one B read a cycle.
// The block takes one request at a time and stalls requests until the current one finishes.
// Reset sets size_n to 64; the A, B and C stores hold undefined data until written.

module matrix_multiply_accumulate #(
   parameter int MAX_N = 64
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input mma_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output mma_pkg::rsp_type rsp_data,
   input logic csr_write_en,
   input logic [mma_pkg::SIZE_W-1:0] csr_write_data
);

   import mma_pkg::*;

   localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int AW = 2 * IW;
   localparam int DEPTH = 1 << AW;
   localparam int ACC_W = PROD_W + IW;
   localparam int TW = ACC_W - FRAC_W + 1;
   localparam int LIM_W = 9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_START,
      ST_MAC,
      ST_DRAIN,
      ST_WB,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [SIZE_W-1:0] size_n_ff;
   logic [IW-1:0] n_last_ff, n_last_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] j_ff, j_in;
   logic [IW-1:0] k_ff, k_in;
   logic sat_ff, sat_in;
   logic inside_ff, inside_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic accept;
   logic slot_free;
   logic [LIM_W-1:0] row_w, col_w, size_w, n_eff;
   logic req_inside;
   logic [AW-1:0] req_addr;

   logic [VALUE_W-1:0] a_rdata, b_rdata, c_rdata;
   logic a_we, b_we, c_we, c_re;
   logic [AW-1:0] c_waddr, c_raddr;
   logic [VALUE_W-1:0] c_wdata;

   dot_ctl_type dot_ctl;
   logic signed [ACC_W-1:0] acc;
   logic dot_busy;

   logic signed [TW-1:0] total;
   logic [TW-VALUE_W:0] total_hi;
   logic wb_sat;
   logic [VALUE_W-1:0] c_new;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign row_w = LIM_W'(req_data.row);
   assign col_w = LIM_W'(req_data.col);
   assign req_inside = (row_w < LIM_W'(MAX_N)) && (col_w < LIM_W'(MAX_N));
   assign req_addr = {row_w[IW-1:0], col_w[IW-1:0]};

   assign size_w = LIM_W'(size_n_ff);
   assign n_eff = (size_w > LIM_W'(MAX_N)) ? LIM_W'(MAX_N) : size_w;

   assign a_we = accept && (req_data.kind == KIND_WRITE_A) && req_inside;
   assign b_we = accept && (req_data.kind == KIND_WRITE_B) && req_inside;
   assign c_we = (accept && (req_data.kind == KIND_WRITE_C) && req_inside)
      || (state_ff == ST_WB);
   assign c_waddr = (state_ff == ST_WB) ? {i_ff, j_ff} : req_addr;
   assign c_wdata = (state_ff == ST_WB) ? c_new : req_data.value;
   assign c_re = (accept && (req_data.kind == KIND_READ_C)) || (state_ff == ST_START);
   assign c_raddr = (state_ff == ST_START) ? {i_ff, j_ff} : req_addr;

   mma_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_a (
      .clock(clock),
      .wr_en(a_we),
      .wr_addr(req_addr),
      .wr_data(req_data.value),
      .rd_en(state_ff == ST_MAC),
      .rd_addr({i_ff, k_ff}),
      .rd_data(a_rdata)
   );

   mma_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_b (
      .clock(clock),
      .wr_en(b_we),
      .wr_addr(req_addr),
      .wr_data(req_data.value),
      .rd_en(state_ff == ST_MAC),
      .rd_addr({k_ff, j_ff}),
      .rd_data(b_rdata)
   );

   mma_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_c (
      .clock(clock),
      .wr_en(c_we),
      .wr_addr(c_waddr),
      .wr_data(c_wdata),
      .rd_en(c_re),
      .rd_addr(c_raddr),
      .rd_data(c_rdata)
   );

   assign dot_ctl.clear = (state_ff == ST_START);
   assign dot_ctl.issue = (state_ff == ST_MAC);

   mma_dot #(.ACC_W(ACC_W)) u_dot (
      .clock(clock),
      .reset(reset),
      .ctl(dot_ctl),
      .a_data($signed(a_rdata)),
      .b_data($signed(b_rdata)),
      .acc(acc),
      .busy(dot_busy)
   );

   // The exact sum is floored to Q16.16 by dropping its fraction bits.
   assign total = TW'($signed(acc[ACC_W-1:FRAC_W])) + TW'($signed(c_rdata));
   assign total_hi = total[TW-1:VALUE_W-1];
   assign wb_sat = !((total_hi == '0) || (total_hi == '1));
   assign c_new = wb_sat ? (total[TW-1] ? Q_MIN : Q_MAX) : total[VALUE_W-1:0];

   always_comb begin
      state_in = state_ff;
      n_last_in = n_last_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      sat_in = sat_ff;
      inside_in = inside_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.kind)
                  KIND_COMPUTE: begin
                     sat_in = 1'b0;
                     i_in = '0;
                     j_in = '0;
                     n_last_in = IW'(n_eff - LIM_W'(1));
                     state_in = (n_eff == '0) ? ST_DONE : ST_START;
                  end
                  KIND_READ_C: begin
                     inside_in = req_inside;
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.result_value = inside_ff ? $signed(c_rdata) : '0;
               rsp_data_in.is_done = 1'b0;
               rsp_data_in.saturated = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_START: begin
            k_in = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            k_in = k_ff + IW'(1);
            if (k_ff == n_last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!dot_busy) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            sat_in = sat_ff | wb_sat;
            state_in = ST_START;
            if (j_ff == n_last_ff) begin
               j_in = '0;
               if (i_ff == n_last_ff) begin
                  state_in = ST_DONE;
               end else begin
                  i_in = i_ff + IW'(1);
               end
            end else begin
               j_in = j_ff + IW'(1);
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.result_value = '0;
               rsp_data_in.is_done = 1'b1;
               rsp_data_in.saturated = sat_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         size_n_ff <= SIZE_N_RESET;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            size_n_ff <= csr_write_data;
         end
      end
      n_last_ff <= n_last_in;
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      sat_ff <= sat_in;
      inside_ff <= inside_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule
